FILE: rtl/core/pse_pkg.sv
// Package: shared types, constants and codes for the postfix stack evaluator.
`default_nettype none
package pse_pkg;

   localparam int unsigned DefStackDepth = 16;
   localparam int unsigned DataWidth     = 32;

   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;
   localparam logic [7:0] ChUpA   = 8'h41;
   localparam logic [7:0] ChUpZ   = 8'h5A;
   localparam logic [7:0] ChLoA   = 8'h61;
   localparam logic [7:0] ChLoZ   = 8'h7A;
   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChStar  = 8'h2A;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChCaret = 8'h5E;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_DIVZERO   = 2'd2,
      ERR_OVERFLOW  = 2'd3
   } err_type;

   typedef struct packed {
      logic [7:0]         token_char;
      logic signed [31:0] operand_value;
      logic               last_token;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_type;

   // Commands from controller to datapath
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_LOAD,     // latch request word
      CMD_RD_RHS,   // start read of top entry
      CMD_RD_LHS,   // capture rhs, start read of next entry
      CMD_CAP_LHS,  // capture lhs
      CMD_STEP,     // set-up, or one iteration of divide or power
      CMD_PUSH,     // push result or token value
      CMD_FINAL     // pop for result and clear
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic is_push;     // letter or digit
      logic iter_done;
      logic last;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/core/pse_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module pse_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write and read at one address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule
`default_nettype wire

FILE: rtl/core/pse_datapath.sv
// Datapath: operand stack, arithmetic and the iterative divide and power unit.
`default_nettype none
module pse_datapath #(
   parameter int unsigned StackDepth = pse_pkg::DefStackDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pse_pkg::req_type req_word,
   input  wire pse_pkg::ctl_type ctl,
   output pse_pkg::sts_type      sts,
   output pse_pkg::rsp_type      rsp_word
);

   localparam int unsigned AW = $clog2(StackDepth);
   localparam int unsigned DW = $clog2(StackDepth + 1);
   localparam logic [DW-1:0] FullCount = DW'(StackDepth);

   pse_pkg::req_type req_ff;
   logic [DW-1:0]  depth_ff, depth_in;
   pse_pkg::err_type err_ff, err_in;
   logic [31:0]    rhs_ff, rhs_in, lhs_ff, lhs_in;
   logic           lhs_ok_ff, lhs_ok_in;
   // iterative unit
   logic [31:0]    acc_ff, acc_in, sq_ff, sq_in, ex_ff, ex_in;
   logic [31:0]    rem_ff, rem_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           neg_ff, neg_in;
   pse_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0]  ram_addr;
   logic           ram_we;
   logic [31:0]    ram_wdata, ram_rdata;

   logic           is_letter, is_digit, is_div, is_pow;
   logic [31:0]    push_val, op_res, abs_l, abs_r;
   logic           op_div0, ovf;
   logic [32:0]    trial;

   assign is_letter = (req_ff.token_char inside {[pse_pkg::ChUpA:pse_pkg::ChUpZ]}) ||
                      (req_ff.token_char inside {[pse_pkg::ChLoA:pse_pkg::ChLoZ]});
   assign is_digit  = req_ff.token_char inside {[pse_pkg::ChZero:pse_pkg::ChNine]};
   assign is_div    = req_ff.token_char == pse_pkg::ChSlash;
   assign is_pow    = req_ff.token_char == pse_pkg::ChCaret;

   assign abs_l = lhs_ff[31] ? (32'd0 - lhs_ff) : lhs_ff;
   assign abs_r = rhs_ff[31] ? (32'd0 - rhs_ff) : rhs_ff;

   // Restoring divide step: shift one dividend bit into the remainder
   assign trial = {rem_ff, ex_ff[31]} - {1'b0, sq_ff};

   pse_ram #(.Width(32), .Depth(StackDepth)) u_stack (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   // Value of the push and its error
   always_comb begin
      op_res  = 32'd0;
      op_div0 = 1'b0;
      if (is_letter) begin
         op_res = req_ff.operand_value;
      end else if (is_digit) begin
         op_res = {24'd0, req_ff.token_char - pse_pkg::ChZero};
      end else begin
         case (req_ff.token_char)
            pse_pkg::ChPlus:  op_res = lhs_ff + rhs_ff;
            pse_pkg::ChMinus: op_res = lhs_ff - rhs_ff;
            pse_pkg::ChStar:  op_res = lhs_ff * rhs_ff;
            pse_pkg::ChSlash: begin
               op_div0 = rhs_ff == 32'd0;
               op_res  = op_div0 ? 32'd0 : (neg_ff ? 32'd0 - acc_ff : acc_ff);
            end
            pse_pkg::ChCaret: begin
               if (rhs_ff[31]) begin
                  op_div0 = lhs_ff == 32'd0;
                  if (lhs_ff == 32'd1) op_res = 32'd1;
                  else if (lhs_ff == 32'hFFFF_FFFF)
                     op_res = rhs_ff[0] ? 32'hFFFF_FFFF : 32'd1;
                  else op_res = 32'd0;
               end else begin
                  op_res = acc_ff;
               end
            end
            default: op_res = 32'd0;
         endcase
      end
   end
   assign push_val = op_res;
   assign ovf      = depth_ff >= FullCount;

   // Stack, operand and iteration registers
   always_comb begin
      depth_in = depth_ff;
      err_in   = err_ff;
      rhs_in = rhs_ff; lhs_in = lhs_ff;
      lhs_ok_in = lhs_ok_ff;
      acc_in = acc_ff; sq_in = sq_ff; ex_in = ex_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; neg_in = neg_ff;
      rsp_in = rsp_ff;
      ram_we = 1'b0;
      ram_wdata = push_val;
      ram_addr = depth_ff[AW-1:0] - AW'(1);
      case (ctl.cmd)
         pse_pkg::CMD_RD_RHS: begin
            ram_addr = depth_ff[AW-1:0] - AW'(1);
         end
         pse_pkg::CMD_RD_LHS: begin
            ram_addr = depth_ff[AW-1:0] - AW'(2);
            if (depth_ff != '0) begin
               depth_in = depth_ff - DW'(1);
               rhs_in   = ram_rdata;
            end else begin
               rhs_in = 32'd1;
               if (err_ff == pse_pkg::ERR_NONE) err_in = pse_pkg::ERR_UNDERFLOW;
            end
         end
         pse_pkg::CMD_CAP_LHS: begin
            lhs_ok_in = depth_ff != '0;
            if (depth_ff != '0) depth_in = depth_ff - DW'(1);
         end
         pse_pkg::CMD_STEP: begin
            if (cnt_ff == 6'd0) begin
               // first cycle: latch lhs and set up unit
               lhs_in = lhs_ok_ff ? lhs_ff : 32'd1;
               if (!lhs_ok_ff && err_ff == pse_pkg::ERR_NONE)
                  err_in = pse_pkg::ERR_UNDERFLOW;
               cnt_in = 6'd1;
               acc_in = is_div ? 32'd0 : 32'd1;
               rem_in = 32'd0;
               neg_in = 1'b0;
               sq_in  = 32'd0;
               ex_in  = 32'd0;
            end else if (cnt_ff == 6'd1) begin
               cnt_in = 6'd2;
               if (is_div) begin
                  sq_in = abs_r; ex_in = abs_l; neg_in = lhs_ff[31] ^ rhs_ff[31];
               end else begin
                  sq_in = lhs_ff; ex_in = rhs_ff;
               end
            end else if (cnt_ff < 6'd34) begin
               cnt_in = cnt_ff + 6'd1;
               if (is_div) begin
                  if (!trial[32]) begin
                     rem_in = trial[31:0];
                     acc_in = {acc_ff[30:0], 1'b1};
                  end else begin
                     rem_in = {rem_ff[30:0], ex_ff[31]};
                     acc_in = {acc_ff[30:0], 1'b0};
                  end
                  ex_in = {ex_ff[30:0], 1'b0};
               end else begin
                  if (ex_ff[0]) acc_in = acc_ff * sq_ff;
                  sq_in = sq_ff * sq_ff;
                  ex_in = {1'b0, ex_ff[31:1]};
               end
            end
         end
         pse_pkg::CMD_PUSH: begin
            cnt_in = 6'd0;
            if (!is_letter && !is_digit && !is_div && !is_pow && !lhs_ok_ff
                && err_ff == pse_pkg::ERR_NONE) begin
               err_in = pse_pkg::ERR_UNDERFLOW;
            end else if (!is_letter && !is_digit && op_div0
                && err_ff == pse_pkg::ERR_NONE) begin
               err_in = pse_pkg::ERR_DIVZERO;
            end
            if (ovf) begin
               if (err_in == pse_pkg::ERR_NONE) err_in = pse_pkg::ERR_OVERFLOW;
            end else begin
               ram_we   = 1'b1;
               ram_addr = depth_ff[AW-1:0];
               depth_in = depth_ff + DW'(1);
            end
         end
         pse_pkg::CMD_FINAL: begin
            rsp_in.result_value = (depth_ff != '0) ? ram_rdata : 32'sd1;
            rsp_in.status = ((depth_ff == '0) && err_ff == pse_pkg::ERR_NONE)
                          ? pse_pkg::ERR_UNDERFLOW : err_ff;
            depth_in = '0;
            err_in   = pse_pkg::ERR_NONE;
         end
         default: ;
      endcase
      // The lhs is captured raw for every operator; the first STEP fixes it up
      if (ctl.cmd == pse_pkg::CMD_CAP_LHS) begin
         lhs_in = ram_rdata;
      end
   end

   // Request capture and registers
   always_ff @(posedge clock) begin
      if (ctl.cmd == pse_pkg::CMD_LOAD) req_ff <= req_word;
      rhs_ff <= rhs_in; lhs_ff <= lhs_in;
      acc_ff <= acc_in; sq_ff <= sq_in; ex_ff <= ex_in; rem_ff <= rem_in;
      neg_ff <= neg_in; rsp_ff <= rsp_in;
      lhs_ok_ff <= lhs_ok_in;
      if (reset) begin
         depth_ff <= '0;
         err_ff   <= pse_pkg::ERR_NONE;
         cnt_ff   <= 6'd0;
      end else begin
         depth_ff <= depth_in;
         err_ff   <= err_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign sts.is_push   = is_letter || is_digit;
   assign sts.iter_done = (is_div || is_pow) ? (cnt_ff == 6'd34) : (cnt_ff == 6'd1);
   assign sts.last      = req_ff.last_token;
   assign rsp_word      = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/core/pse_ctrl.sv
// Controller: sequences one token word through the datapath.
`default_nettype none
module pse_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire pse_pkg::sts_type sts,
   output pse_pkg::ctl_type      ctl
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RHS, S_LHS, S_CAP, S_STEP, S_PUSH,
      S_FRD, S_FWAIT, S_FINAL, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl.cmd = pse_pkg::CMD_NOP;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.cmd = pse_pkg::CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: state_in = sts.is_push ? S_PUSH : S_RHS;
         S_RHS: begin ctl.cmd = pse_pkg::CMD_RD_RHS; state_in = S_LHS; end
         S_LHS: begin ctl.cmd = pse_pkg::CMD_RD_LHS; state_in = S_CAP; end
         S_CAP: begin ctl.cmd = pse_pkg::CMD_CAP_LHS; state_in = S_STEP; end
         S_STEP: begin
            ctl.cmd = pse_pkg::CMD_STEP;
            if (sts.iter_done) state_in = S_PUSH;
         end
         S_PUSH: begin
            ctl.cmd = pse_pkg::CMD_PUSH;
            state_in = sts.last ? S_FRD : S_IDLE;
         end
         S_FRD: begin ctl.cmd = pse_pkg::CMD_RD_RHS; state_in = S_FWAIT; end
         S_FWAIT: state_in = rsp_valid_ff ? S_FWAIT : S_FINAL;
         S_FINAL: begin
            ctl.cmd = pse_pkg::CMD_FINAL;
            state_in = S_OUT;
         end
         S_OUT: begin rsp_valid_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator.
`default_nettype none
// Takes one postfix token word at a time and keeps a STACK_DEPTH-entry operand
// stack in a single-port RAM. A letter or digit is pushed directly; + - * and
// unknown operators pop two operands and push one; / and ^ also run the shared
// 32-step divide / square-and-multiply unit. A word marked last then pops
// the result; the result register holds it until taken. Further tokens are
// accepted while it waits, but the final pop of a later word marked last
// waits until the held result has been taken.
module postfix_stack_evaluator #(
   parameter int unsigned STACK_DEPTH = pse_pkg::DefStackDepth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pse_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pse_pkg::rsp_type      rsp_data
);

   pse_pkg::ctl_type ctl;
   pse_pkg::sts_type sts;

   pse_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .ctl(ctl)
   );

   pse_datapath #(.StackDepth(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .req_word(req_data), .ctl(ctl),
      .sts(sts), .rsp_word(rsp_data)
   );

`ifndef SYNTHESIS
   // Held result word stays put while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed under stall");
   // No word taken while a result is being formed
   assert property (@(posedge clock) disable iff (reset)
      ctl.cmd == pse_pkg::CMD_FINAL |-> req_stall)
      else $error("input accepted during final pop");
`endif

endmodule
`default_nettype wire

FILE: bench/postfix_stack_evaluator_tb.sv
// Testbench for the postfix stack evaluator: directed and random expressions.
`timescale 1ns / 1ps
module postfix_stack_evaluator_tb;

   localparam int unsigned Depth    = 16;
   localparam int unsigned IdleLim  = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pse_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pse_pkg::rsp_type rsp_data;

   postfix_stack_evaluator #(.STACK_DEPTH(Depth)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [31:0]      eval_stack [Depth];
   int unsigned      eval_depth;
   pse_pkg::err_type eval_err;
   pse_pkg::rsp_type expected_results [$];
   int               fail_count = 0;
   int               idle_cycles = 0;
   bit               quiet = 1'b0;

   function automatic void note_err(pse_pkg::err_type e);
      if (eval_err == pse_pkg::ERR_NONE) eval_err = e;
   endfunction

   function automatic void push_word(logic [31:0] v);
      if (eval_depth >= Depth) begin
         note_err(pse_pkg::ERR_OVERFLOW);
      end else begin
         eval_stack[eval_depth] = v;
         eval_depth++;
      end
   endfunction

   function automatic logic [31:0] pop_word();
      if (eval_depth == 0) begin
         note_err(pse_pkg::ERR_UNDERFLOW);
         return 32'd1;
      end
      eval_depth--;
      return eval_stack[eval_depth];
   endfunction

   function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
      logic [31:0] ua, ub, q;
      if (b == 0) begin
         note_err(pse_pkg::ERR_DIVZERO);
         return 32'd0;
      end
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q  = ua / ub;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic logic [31:0] int_pow(logic [31:0] b, logic [31:0] e);
      logic [31:0] acc, sq, x;
      acc = 32'd1; sq = b; x = e;
      if (e[31]) begin
         if (b == 0) begin
            note_err(pse_pkg::ERR_DIVZERO);
            return 32'd0;
         end
         if (b == 32'd1) return 32'd1;
         if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      while (x != 0) begin
         if (x[0]) acc = acc * sq;
         sq = sq * sq;
         x = x >> 1;
      end
      return acc;
   endfunction

   // work out what one token word does to the stack
   function automatic void predict_token(pse_pkg::req_type w);
      logic [31:0]      rhs, lhs, r;
      pse_pkg::rsp_type res;
      logic [7:0]       t;
      t = w.token_char;
      if ((t >= pse_pkg::ChUpA && t <= pse_pkg::ChUpZ) ||
          (t >= pse_pkg::ChLoA && t <= pse_pkg::ChLoZ)) begin
         push_word(w.operand_value);
      end else if (t >= pse_pkg::ChZero && t <= pse_pkg::ChNine) begin
         push_word({24'd0, t - pse_pkg::ChZero});
      end else begin
         rhs = pop_word();
         lhs = pop_word();
         case (t)
            pse_pkg::ChPlus:  r = lhs + rhs;
            pse_pkg::ChMinus: r = lhs - rhs;
            pse_pkg::ChStar:  r = lhs * rhs;
            pse_pkg::ChSlash: r = trunc_div(lhs, rhs);
            pse_pkg::ChCaret: r = int_pow(lhs, rhs);
            default: r = 32'd0;
         endcase
         push_word(r);
      end
      if (w.last_token) begin
         res.result_value = pop_word();
         res.status = eval_err;
         expected_results.push_back(res);
         eval_depth = 0;
         eval_err = pse_pkg::ERR_NONE;
      end
   endfunction

   task automatic send_word(logic [7:0] t, logic [31:0] v, bit last);
      pse_pkg::req_type w;
      w.token_char = t; w.operand_value = v; w.last_token = last;
      while (!quiet && $urandom_range(99) < 15) begin
         @(posedge clock);
         req_valid <= 1'b0;
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      predict_token(w);
      do @(posedge clock); while (req_stall);
      req_valid <= 1'b0;
   endtask

   // lower valid after the last item has been sent
   task automatic send_expr_end();
      @(posedge clock);
      req_valid <= 1'b0;
   endtask

   // result check and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %h/%0d",
                        $time, rsp_data.result_value, rsp_data.status);
               fail_count++;
            end else begin
               pse_pkg::rsp_type e;
               e = expected_results.pop_front();
               if (rsp_data.result_value !== e.result_value)
                  begin
                  $display("%0t result_value: expected %h, actual %h",
                           $time, e.result_value, rsp_data.result_value);
                  fail_count++;
               end
               if (rsp_data.status !== e.status) begin
                  $display("%0t status: expected %0d, actual %0d",
                           $time, e.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLim) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [7:0] rand_letter();
      return $urandom_range(1) ? 8'(pse_pkg::ChUpA + $urandom_range(25))
                               : 8'(pse_pkg::ChLoA + $urandom_range(25));
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'($signed($urandom_range(8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] rand_op();
      case ($urandom_range(9))
         0, 1: return pse_pkg::ChPlus;
         2, 3: return pse_pkg::ChMinus;
         4, 5: return pse_pkg::ChStar;
         6, 7: return pse_pkg::ChSlash;
         8:    return pse_pkg::ChCaret;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_arith();
      send_word("a", 32'h7FFF_FFFF, 0); send_word("1", 0, 0);
      send_word(pse_pkg::ChPlus, 0, 1);
      send_word("Z", 32'h8000_0000, 0); send_word("z", 32'hFFFF_FFFF, 0);
      send_word(pse_pkg::ChSlash, 0, 1);
      send_word("9", 0, 0); send_word("0", 0, 0); send_word(pse_pkg::ChSlash, 0, 1);
      send_word("7", 0, 0); send_word("b", 32'hFFFF_FFFD, 0);
      send_word(pse_pkg::ChSlash, 0, 1);
      send_word("c", 32'h1234_5678, 0); send_word("d", 32'h9ABC_DEF0, 0);
      send_word(pse_pkg::ChStar, 0, 0); send_word("3", 0, 0);
      send_word(pse_pkg::ChMinus, 0, 1);
   endtask

   task automatic test_power();
      send_word("3", 0, 0); send_word("e", 32'd21, 0); send_word(pse_pkg::ChCaret, 0, 1);
      send_word("0", 0, 0); send_word("0", 0, 0); send_word(pse_pkg::ChCaret, 0, 1);
      send_word("0", 0, 0); send_word("n", 32'hFFFF_FFFF, 0);
      send_word(pse_pkg::ChCaret, 0, 1);
      send_word("m", 32'hFFFF_FFFF, 0); send_word("n", 32'hFFFF_FFFB, 0);
      send_word(pse_pkg::ChCaret, 0, 1);
      send_word("1", 0, 0); send_word("n", 32'h8000_0000, 0);
      send_word(pse_pkg::ChCaret, 0, 1);
      send_word("5", 0, 0); send_word("n", 32'hFFFF_FFFE, 0);
      send_word(pse_pkg::ChCaret, 0, 1);
   endtask

   task automatic test_stack_errors();
      send_word(pse_pkg::ChPlus, 0, 1);       // empty pops
      send_word(8'h00, 0, 0); send_word(8'hFF, 32'h0, 1);
      send_word("4", 0, 0); send_word(8'h7B, 0, 1); // unknown op on one operand
      for (int i = 0; i < Depth + 2; i++) send_word("8", 0, 0);
      send_word("9", 0, 1);                   // push when full
      send_word("q", 32'h5555_AAAA, 1);
   endtask

   task automatic test_random(int unsigned n_items);
      int unsigned sent;
      sent = 0;
      while (sent < n_items) begin
         int unsigned len, d;
         quiet = (sent > n_items / 3) && (sent < n_items / 2);
         if ($urandom_range(9) < 8) begin
            // well-formed expression
            len = $urandom_range(1, 8);
            d = 0;
            for (int i = 0; i < 2 * len - 1; i++) begin
               bit last;
               last = (i == 2 * len - 2);
               if (d >= 2 && ($urandom_range(1) || (2 * len - 1 - i) <= d - 1)) begin
                  send_word(rand_op(), $urandom, last);
                  d--;
               end else begin
                  if ($urandom_range(2) == 0)
                     send_word(8'(pse_pkg::ChZero + $urandom_range(9)), $urandom, last);
                  else
                     send_word(rand_letter(), rand_operand(), last);
                  d++;
               end
               sent++;
            end
         end else begin
            // noise
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
               send_word(8'($urandom), $urandom, (i == len - 1) || ($urandom_range(7) == 0));
               sent++;
            end
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      eval_depth = 0;
      eval_err = pse_pkg::ERR_NONE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_arith();
      test_power();
      test_stack_errors();
      test_random(490);
      send_expr_end();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
